// ----- sv/mmbn_pkg.sv -----
// ----------------------------------------------------------------------------
// Min-max block normalizer package
// Shared command codes and fixed sizes of the normalizer.
// ----------------------------------------------------------------------------
package mmbn_pkg;

	localparam int unsigned ValueBits  = 16;
	localparam int unsigned DivSteps   = 17;
	localparam int unsigned QueueDepth = 4;

	typedef enum logic {
		CMD_LOAD   = 1'b0,
		CMD_DENORM = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_NO_RECORD  = 2'd1,
		STAT_ZERO_RANGE = 2'd2
	} status_t;

endpackage

// ----- sv/mmbn_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mmbn_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AddrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AddrBits-1:0] waddr,
	input  logic [WIDTH-1:0]    wdata,
	input  logic                re,
	input  logic [AddrBits-1:0] raddr,
	output logic [WIDTH-1:0]    rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/mmbn_fifo.sv -----
// ----------------------------------------------------------------------------
// Command queue
// Small register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module mmbn_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4,
	localparam int unsigned PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int unsigned CntBits = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam logic [PtrBits-1:0] LastPtr = PtrBits'(DEPTH - 1);
	localparam logic [CntBits-1:0] FullCnt = CntBits'(DEPTH);

	logic [WIDTH-1:0]   mem_q [DEPTH];
	logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntBits-1:0] count_q;

	assign full     = (count_q == FullCnt);
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("Command queue written while full.");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("Command queue read while empty.");

endmodule

// ----- sv/mmbn_front.sv -----
// ----------------------------------------------------------------------------
// Normalizer front end
// Accepts requests, stores samples, tracks the block range and the record,
// and queues run and denormalize commands for the back end.
// ----------------------------------------------------------------------------
module mmbn_front #(
	parameter int unsigned MAX_BLOCK   = 64,
	parameter int unsigned SAMPLE_BITS = 16,
	localparam int unsigned CntBits  = $clog2(MAX_BLOCK + 1),
	localparam int unsigned AddrBits = $clog2(MAX_BLOCK),
	localparam int unsigned TokBits  = 2 + mmbn_pkg::ValueBits + CntBits + 2 * SAMPLE_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [mmbn_pkg::ValueBits-1:0]   s_tdata,
	input  logic                             s_tuser,
	input  logic                             s_tlast,
	input  logic                             run_done,
	output logic                             q_push,
	output logic [TokBits-1:0]               q_data,
	input  logic                             q_full,
	output logic                             ram_we,
	output logic [AddrBits-1:0]              ram_waddr,
	output logic [SAMPLE_BITS-1:0]           ram_wdata
);

	import mmbn_pkg::*;

	localparam logic signed [SAMPLE_BITS-1:0] SMax = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMin = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [CntBits-1:0] FullCount = CntBits'(MAX_BLOCK);

	logic [CntBits-1:0]            fill_q;
	logic signed [SAMPLE_BITS-1:0] min_q, max_q;
	logic                          rec_q;
	logic                          run_busy_q;

	logic                          accept, is_denorm, first, has_room;
	logic [ValueBits:0]            value_ext;
	logic signed [SAMPLE_BITS-1:0] x, base_min, base_max, new_min, new_max;
	logic [CntBits-1:0]            new_fill;

	assign s_tready  = !q_full && !run_busy_q;
	assign accept    = s_tvalid && s_tready;
	assign is_denorm = (cmd_t'(s_tuser) == CMD_DENORM);

	assign value_ext = {1'b0, s_tdata};
	assign x         = signed'(SAMPLE_BITS'(value_ext));

	assign first    = (fill_q == '0);
	assign has_room = (fill_q < FullCount);
	assign base_min = first ? x : min_q;
	assign base_max = first ? x : max_q;
	assign new_min  = (has_room && (x < base_min)) ? x : base_min;
	assign new_max  = (has_room && (x > base_max)) ? x : base_max;
	assign new_fill = has_room ? fill_q + 1'b1 : fill_q;

	assign ram_we    = accept && !is_denorm && has_room;
	assign ram_waddr = fill_q[AddrBits-1:0];
	assign ram_wdata = x;

	assign q_push = accept && (is_denorm || s_tlast);
	assign q_data = is_denorm ? {min_q, max_q, CntBits'(0), s_tdata, rec_q, CMD_DENORM}
	                          : {new_min, new_max, new_fill, s_tdata, 1'b1, CMD_LOAD};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			min_q      <= SMax;
			max_q      <= SMin;
			rec_q      <= 1'b0;
			run_busy_q <= 1'b0;
		end else begin
			if (run_done) begin
				run_busy_q <= 1'b0;
			end
			if (accept) begin
				if (is_denorm) begin
					if (s_tlast) begin
						rec_q <= 1'b0;
					end
				end else begin
					min_q <= new_min;
					max_q <= new_max;
					if (s_tlast) begin
						fill_q     <= '0;
						rec_q      <= 1'b1;
						run_busy_q <= 1'b1;
					end else begin
						fill_q <= new_fill;
						if (first) begin
							rec_q <= 1'b0;
						end
					end
				end
			end
		end
	end

	a_busy_empty_block: assert property (@(posedge clk) disable iff (!arst_n)
		run_busy_q |-> (fill_q == '0))
		else $error("Samples held while a block is still being emitted.");

	a_busy_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		run_busy_q |-> !s_tready)
		else $error("Input accepted while a block is still being emitted.");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("Command pushed into a full queue.");

endmodule

// ----- sv/mmbn_back.sv -----
// ----------------------------------------------------------------------------
// Normalizer back end
// Executes queued commands: emits a closed block through a serial divider,
// or maps one value back through the recorded range (or flags a missing record), into an output register.
// ----------------------------------------------------------------------------
module mmbn_back #(
	parameter int unsigned MAX_BLOCK   = 64,
	parameter int unsigned SAMPLE_BITS = 16,
	localparam int unsigned CntBits  = $clog2(MAX_BLOCK + 1),
	localparam int unsigned AddrBits = $clog2(MAX_BLOCK),
	localparam int unsigned TokBits  = 2 + mmbn_pkg::ValueBits + CntBits + 2 * SAMPLE_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_empty,
	output logic                           q_pop,
	input  logic [TokBits-1:0]             q_data,
	output logic                           ram_re,
	output logic [AddrBits-1:0]            ram_raddr,
	input  logic [SAMPLE_BITS-1:0]         ram_rdata,
	output logic                           run_done,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [mmbn_pkg::ValueBits-1:0] m_tdata,
	output logic [1:0]                     m_tuser,
	output logic                           m_tlast
);

	import mmbn_pkg::*;

	localparam int unsigned ValLsb   = 2;
	localparam int unsigned CntLsb   = ValLsb + ValueBits;
	localparam int unsigned MaxLsb   = CntLsb + CntBits;
	localparam int unsigned MinLsb   = MaxLsb + SAMPLE_BITS;
	localparam int unsigned QBits    = DivSteps;
	localparam int unsigned StepBits = $clog2(DivSteps);
	localparam int unsigned ProdBits = SAMPLE_BITS + ValueBits + 1;
	localparam int unsigned NumBits  = SAMPLE_BITS + ValueBits + 2;
	localparam int unsigned RBits    = SAMPLE_BITS + 2;

	localparam logic signed [SAMPLE_BITS-1:0] SMax = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMin = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [RBits-1:0] LimPos = {3'b000, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [RBits-1:0] LimNeg = {3'b001, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [NumBits-1:0] Half = NumBits'(32768);
	localparam logic [StepBits-1:0] FirstStep = StepBits'(DivSteps - 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DN_MUL,
		S_DN_ADD,
		S_DN_RND,
		S_DN_SAT,
		S_RD,
		S_LOAD,
		S_DIV,
		S_FIN,
		S_EMIT
	} state_t;

	state_t                        state_q;
	cmd_t                          kind_q;
	logic signed [SAMPLE_BITS-1:0] min_q, max_q;
	logic [SAMPLE_BITS-1:0]        range_q;
	logic [CntBits-1:0]            cnt_q, idx_q;
	logic signed [ValueBits-1:0]   val_q;
	logic signed [ProdBits-1:0]    prod_q;
	logic signed [NumBits-1:0]     num_q;
	logic [RBits-1:0]              r_q;
	logic [SAMPLE_BITS:0]          rem_q, div_q;
	logic [QBits-1:0]              low_q;
	logic [StepBits-1:0]           step_q;
	logic                          neg_q;
	logic [ValueBits-1:0]          res_q;
	status_t                       stat_q;
	logic                          last_q;
	logic                          out_valid_q;
	logic [ValueBits-1:0]          out_data_q;
	status_t                       out_stat_q;
	logic                          out_last_q;

	logic signed [SAMPLE_BITS-1:0]   tok_min, tok_max;
	logic [SAMPLE_BITS:0]            tok_diff;
	logic                            out_free;
	logic                            emit;
	logic signed [SAMPLE_BITS+1:0]   t_w;
	logic [SAMPLE_BITS+1:0]          t_mag;
	logic [SAMPLE_BITS+QBits-1:0]    dvd_w;
	logic [SAMPLE_BITS+1:0]          cand_w, trial_w;
	logic [QBits-1:0]                q_neg;
	logic signed [SAMPLE_BITS:0]     sum_mm;
	logic [NumBits-1:0]              num_mag, num_rnd;
	logic [RBits-1:0]                r_neg;
	logic [SAMPLE_BITS-1:0]          dn_val;

	assign tok_min  = signed'(q_data[MinLsb +: SAMPLE_BITS]);
	assign tok_max  = signed'(q_data[MaxLsb +: SAMPLE_BITS]);
	assign tok_diff = {tok_max[SAMPLE_BITS-1], tok_max} - {tok_min[SAMPLE_BITS-1], tok_min};

	assign out_free  = !out_valid_q || m_tready;
	assign emit      = (state_q == S_EMIT) && out_free;
	assign q_pop     = (state_q == S_IDLE) && !q_empty;
	assign ram_re    = (state_q == S_RD);
	assign ram_raddr = idx_q[AddrBits-1:0];
	assign run_done  = (state_q == S_EMIT) && out_free && (kind_q == CMD_LOAD) && last_q;

	assign t_w   = ((SAMPLE_BITS+2)'(signed'(ram_rdata)) <<< 1)
	             - (SAMPLE_BITS+2)'(max_q) - (SAMPLE_BITS+2)'(min_q);
	assign t_mag = t_w[SAMPLE_BITS+1] ? (SAMPLE_BITS+2)'(0) - t_w : t_w;
	assign dvd_w = {1'b0, t_mag[SAMPLE_BITS-1:0], 16'h0000}
	             + (SAMPLE_BITS+QBits)'(range_q);

	assign cand_w  = {rem_q, low_q[QBits-1]};
	assign trial_w = cand_w - {1'b0, div_q};
	assign q_neg   = QBits'(0) - low_q;

	assign sum_mm  = (SAMPLE_BITS+1)'(max_q) + (SAMPLE_BITS+1)'(min_q);
	assign num_mag = num_q[NumBits-1] ? NumBits'(0) - num_q : num_q;
	assign num_rnd = num_mag + Half;
	assign r_neg   = RBits'(0) - r_q;
	assign dn_val  = neg_q ? r_neg[SAMPLE_BITS-1:0] : r_q[SAMPLE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= CMD_LOAD;
			min_q       <= '0;
			max_q       <= '0;
			range_q     <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			val_q       <= '0;
			prod_q      <= '0;
			num_q       <= '0;
			r_q         <= '0;
			rem_q       <= '0;
			div_q       <= '0;
			low_q       <= '0;
			step_q      <= '0;
			neg_q       <= 1'b0;
			res_q       <= '0;
			stat_q      <= STAT_OK;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_stat_q  <= STAT_OK;
			out_last_q  <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						kind_q  <= cmd_t'(q_data[0]);
						min_q   <= tok_min;
						max_q   <= tok_max;
						range_q <= tok_diff[SAMPLE_BITS-1:0];
						cnt_q   <= q_data[CntLsb +: CntBits];
						val_q   <= signed'(q_data[ValLsb +: ValueBits]);
						idx_q   <= '0;
						if (cmd_t'(q_data[0]) == CMD_LOAD) begin
							state_q <= S_RD;
						end else if (!q_data[1]) begin
							res_q   <= '0;
							stat_q  <= STAT_NO_RECORD;
							last_q  <= 1'b1;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_DN_MUL;
						end
					end
				end
				S_DN_MUL: begin
					prod_q  <= ProdBits'(val_q) * ProdBits'(signed'({1'b0, range_q}));
					state_q <= S_DN_ADD;
				end
				S_DN_ADD: begin
					num_q   <= NumBits'(prod_q) + (NumBits'(sum_mm) <<< 15);
					state_q <= S_DN_RND;
				end
				S_DN_RND: begin
					r_q     <= num_rnd[NumBits-1:16];
					neg_q   <= num_q[NumBits-1];
					state_q <= S_DN_SAT;
				end
				S_DN_SAT: begin
					if (!neg_q && (r_q > LimPos)) begin
						res_q <= ValueBits'(SMax);
					end else if (neg_q && (r_q > LimNeg)) begin
						res_q <= ValueBits'(SMin);
					end else begin
						res_q <= ValueBits'(signed'(dn_val));
					end
					stat_q  <= STAT_OK;
					last_q  <= 1'b1;
					state_q <= S_EMIT;
				end
				S_RD: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					last_q <= (idx_q == cnt_q - 1'b1);
					neg_q  <= t_w[SAMPLE_BITS+1];
					rem_q  <= {1'b0, dvd_w[SAMPLE_BITS+QBits-1:QBits]};
					low_q  <= dvd_w[QBits-1:0];
					div_q  <= {range_q, 1'b0};
					step_q <= FirstStep;
					if (range_q == '0) begin
						res_q   <= '0;
						stat_q  <= STAT_ZERO_RANGE;
						state_q <= S_EMIT;
					end else begin
						stat_q  <= STAT_OK;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (!trial_w[SAMPLE_BITS+1]) begin
						rem_q <= trial_w[SAMPLE_BITS:0];
						low_q <= {low_q[QBits-2:0], 1'b1};
					end else begin
						rem_q <= cand_w[SAMPLE_BITS:0];
						low_q <= {low_q[QBits-2:0], 1'b0};
					end
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (neg_q) begin
						res_q <= q_neg[ValueBits-1:0];
					end else if (low_q[QBits-1:ValueBits-1] != '0) begin
						res_q <= ValueBits'(SMax >>> (SAMPLE_BITS - 1)) ^ 16'h8000 ^ 16'hFFFF;
					end else begin
						res_q <= low_q[ValueBits-1:0];
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_data_q  <= res_q;
						out_stat_q  <= stat_q;
						out_last_q  <= last_q;
						if ((kind_q == CMD_LOAD) && !last_q) begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_RD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_stat_q;
	assign m_tlast  = out_last_q;

	a_zero_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == STAT_ZERO_RANGE)) |-> (m_tdata == '0))
		else $error("Zero-range result carries a nonzero value.");

	a_no_record_single: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == STAT_NO_RECORD)) |-> (m_tlast && (m_tdata == '0)))
		else $error("Missing-record result is not a single zero result.");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (div_q != '0))
		else $error("Divider running with a zero divisor.");

endmodule

// ----- sv/min_max_block_normalizer.sv -----
// ----------------------------------------------------------------------------
// Min-max block normalizer
// Maps a block of signed samples to Q1.15 in [-1,1] by its minimum and
// maximum, and maps Q1.15 values back through the recorded range.
// ----------------------------------------------------------------------------
//  Channel  Direction  Request fields
//  s_*      in         tdata: value; tuser: command; tlast: last
//  m_*      out        tdata: result; tuser: status; tlast: end_of_run
//
// Requests are taken one per cycle unless the input stalls; loads go to the
// sample memory, and closing loads and denormalize requests enter a four-entry
// command queue. Each normalized sample passes through the back end as one
// sample-memory read, a setup step, 17 steps of the serial divider, a sign and
// saturation step and a write into the output register; a zero-range sample
// skips the divider. A denormalize request leaves the queue and then passes
// through multiply, add, round and saturate steps. The input stalls from the
// last load of a block until its final result is placed in the output
// register, or while the queue is full. Reset needs no clearing pass; the
// sample memory is only read where the open block wrote it.
// ----------------------------------------------------------------------------
module min_max_block_normalizer #(
	parameter int unsigned MAX_BLOCK   = 64,
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [mmbn_pkg::ValueBits-1:0] s_tdata,  // value
	input  logic                           s_tuser,  // command
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [mmbn_pkg::ValueBits-1:0] m_tdata,  // result
	output logic [1:0]                     m_tuser,  // status
	output logic                           m_tlast
);

	import mmbn_pkg::*;

	localparam int unsigned CntBits  = $clog2(MAX_BLOCK + 1);
	localparam int unsigned AddrBits = $clog2(MAX_BLOCK);
	localparam int unsigned TokBits  = 2 + ValueBits + CntBits + 2 * SAMPLE_BITS;

	logic                   q_push, q_full, q_pop, q_empty;
	logic [TokBits-1:0]     q_push_data, q_pop_data;
	logic                   ram_we, ram_re;
	logic [AddrBits-1:0]    ram_waddr, ram_raddr;
	logic [SAMPLE_BITS-1:0] ram_wdata, ram_rdata;
	logic                   run_done;

	mmbn_front #(
		.MAX_BLOCK   (MAX_BLOCK),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.run_done  (run_done),
		.q_push    (q_push),
		.q_data    (q_push_data),
		.q_full    (q_full),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	mmbn_fifo #(
		.WIDTH (TokBits),
		.DEPTH (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.empty     (q_empty)
	);

	mmbn_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_BLOCK)
	) u_samples (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	mmbn_back #(
		.MAX_BLOCK   (MAX_BLOCK),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.q_data    (q_pop_data),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.run_done  (run_done),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
